@@ hw/rtl/assert_macros.svh @@
// assertion macros for the rtl files
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every cycle outside reset
`define CHK_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/oomvs_pkg.sv @@
// package for the oom victim selector: field widths, codes, attribute bits
// no dependencies
package oomvs_pkg;

  localparam int ScoreBitsDefault = 64;

  localparam logic [1:0] CMD_TASK  = 2'd0;
  localparam logic [1:0] CMD_CHILD = 2'd1;
  localparam logic [1:0] CMD_END   = 2'd2;

  localparam logic [1:0] ST_CHOSEN = 2'd0;
  localparam logic [1:0] ST_NONE   = 2'd1;
  localparam logic [1:0] ST_ABORT  = 2'd2;

  localparam logic CFG_UPTIME = 1'b0;
  localparam logic CFG_SHIFT  = 1'b1;

  localparam int AT_HAS_MM    = 0;
  localparam int AT_INIT      = 1;
  localparam int AT_MEMDIE    = 2;
  localparam int AT_EXITING   = 3;
  localparam int AT_CURRENT   = 4;
  localparam int AT_SWAPOFF   = 5;
  localparam int AT_NICED     = 6;
  localparam int AT_SUPERUSER = 7;
  localparam int AT_RAWIO     = 8;
  localparam int AT_OVERLAP   = 9;
  localparam int AT_DISABLED  = 10;
  localparam int AT_SHARES_MM = 11;

  localparam logic [4:0] CPU_SHIFT_RESET = 5'd11;

endpackage

@@ hw/rtl/oomvs_if.sv @@
// handshake interfaces for input, result and configuration channels
// no dependencies
interface oomvs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [21:0] task_id;
  logic [31:0] vm_pages;
  logic [47:0] cpu_jiffies;
  logic [31:0] start_seconds;
  logic [11:0] attributes;
  logic signed [4:0] adjust;
  modport source(output valid, cmd, task_id, vm_pages, cpu_jiffies, start_seconds,
                 attributes, adjust, input ready);
  modport sink(input valid, cmd, task_id, vm_pages, cpu_jiffies, start_seconds,
               attributes, adjust, output ready);
endinterface

interface oomvs_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [21:0] chosen_task;
  logic [63:0] best_score;
  modport source(output valid, status, chosen_task, best_score, input ready);
  modport sink(input valid, status, chosen_task, best_score, output ready);
endinterface

interface oomvs_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [31:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

@@ hw/rtl/oomvs_arith.sv @@
// shared multi-cycle unit: integer square root or unsigned division, one bit a cycle
// no dependencies; the width comes from the parameter W
module oomvs_arith #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic         is_sqrt,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic         done,
  output logic [W-1:0] result
);
  localparam int CW = $clog2(W + 1);

  logic         busy;
  logic         op_sqrt;
  logic [W-1:0] x;
  logic [W-1:0] rem;
  logic [W-1:0] quo;
  logic [W-1:0] dvs;
  logic [W-1:0] bitm;
  logic [CW-1:0] cnt;
  logic [W:0]   rem_sh;
  logic [W-1:0] trial;

  assign rem_sh = {rem, x[W-1]};
  assign trial  = quo | bitm;

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy    <= 1'b1;
      op_sqrt <= is_sqrt;
      x       <= a;
      dvs     <= b;
      rem     <= '0;
      quo     <= '0;
      bitm    <= W'(1) << (W - 2);
      cnt     <= CW'(W);
    end else if (busy) begin
      if (op_sqrt) begin
        // restoring digit-by-digit root, two bits a step
        if (x >= trial) begin
          x   <= x - trial;
          quo <= (quo >> 1) | bitm;
        end else begin
          quo <= quo >> 1;
        end
        bitm <= bitm >> 2;
        if (bitm == '0 || (bitm >> 2) == '0) begin
          busy   <= 1'b0;
          done   <= 1'b1;
          result <= (x >= trial) ? ((quo >> 1) | bitm) : (quo >> 1);
        end
      end else begin
        x <= x << 1;
        if (rem_sh >= {1'b0, dvs}) begin
          rem <= W'(rem_sh - {1'b0, dvs});
          quo <= {quo[W-2:0], 1'b1};
        end else begin
          rem <= rem_sh[W-1:0];
          quo <= {quo[W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy   <= 1'b0;
          done   <= 1'b1;
          result <= {quo[W-2:0], rem_sh >= {1'b0, dvs}};
        end
      end
    end
  end
endmodule

@@ hw/rtl/oom_victim_selector.sv @@
// oom victim selector top level: scan sequencer, scoring and choice registers
// depends on oomvs_pkg, oomvs_if, oomvs_arith and assert_macros.svh
//
//  channel  | dir | contents
//  in_ch    | in  | cmd, task_id, vm_pages, cpu_jiffies, start_seconds, attributes, adjust
//  out_ch   | out | status, chosen_task, best_score (one word per end item)
//  cfg_ch   | in  | index, data (uptime_seconds, cpu_time_shift)
//
// child words update the pending task's points without leaving the idle state;
// a task or end word that judges a pending task runs up to three roots and two
// divisions in the shared arithmetic unit; a division is skipped when its root is zero
// an end word holds the input until its result word is taken
// reset is synchronous and clears the scan state; config is always ready
`include "assert_macros.svh"
module oom_victim_selector #(
  parameter int SCORE_BITS = oomvs_pkg::ScoreBitsDefault
) (
  input  logic  clk,
  input  logic  rst,
  oomvs_in_if.sink    in_ch,
  oomvs_out_if.source out_ch,
  oomvs_cfg_if.sink   cfg_ch
);
  localparam int W = SCORE_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_JUDGE, S_SQ1, S_DIV1, S_SQ2, S_SQ3, S_DIV2, S_FIN, S_UPDATE, S_LOAD, S_OUT
  } state_t;

  state_t state;

  logic [31:0] uptime;
  logic [4:0]  cpu_shift;

  logic        pend_valid;
  logic [21:0] pend_id;
  logic [W-1:0] pend_points;
  logic [47:0] pend_cpu;
  logic [31:0] pend_start;
  logic [11:0] pend_attrs;
  logic signed [4:0] pend_adjust;
  logic        have_choice;
  logic [21:0] chosen_id;
  logic [W-1:0] top_score;
  logic        aborted;
  logic [W-1:0] pts;
  logic [1:0]  cur_cmd;

  // fields of the accepted word, kept while the pending task is judged
  logic [21:0] word_id;
  logic [31:0] word_vm;
  logic [47:0] word_cpu;
  logic [31:0] word_start;
  logic [11:0] word_attrs;
  logic signed [4:0] word_adj;

  logic         au_start;
  logic         au_sqrt;
  logic [W-1:0] au_a;
  logic         au_done;
  logic [W-1:0] au_res;

  logic [W-1:0] cpu_sh;
  logic [31:0]  run_t;
  logic [W-1:0] p_adj;
  logic [W-1:0] p_nice;

  logic [W-1:0] child_add;

  oomvs_arith #(.W(W)) u_arith (
    .clk(clk), .rst(rst), .start(au_start), .is_sqrt(au_sqrt),
    .a(au_a), .b(au_res), .done(au_done), .result(au_res)
  );

  // cpu time and run time, from the pending task and the configured shift and uptime
  assign cpu_sh = W'({16'd0, pend_cpu >> cpu_shift});
  assign run_t  = (uptime >= pend_start) ? ((uptime - pend_start) >> 10) : 32'd0;
  assign child_add = W'(in_ch.vm_pages >> 1) + W'(1);

  // fixed scaling after the divisions
  always_comb begin
    p_nice = pend_attrs[oomvs_pkg::AT_NICED] ? (pts << 1) : pts;
    if (pend_attrs[oomvs_pkg::AT_SUPERUSER]) p_nice = p_nice >> 2;
    if (pend_attrs[oomvs_pkg::AT_RAWIO]) p_nice = p_nice >> 2;
    if (!pend_attrs[oomvs_pkg::AT_OVERLAP]) p_nice = p_nice >> 3;
    if (pend_adjust > 0) begin
      p_adj = ((p_nice == '0) ? W'(1) : p_nice) << pend_adjust[3:0];
    end else if (pend_adjust < 0) begin
      p_adj = p_nice >> (5'(-pend_adjust));
    end else begin
      p_adj = p_nice;
    end
  end

  assign in_ch.ready  = (state == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      uptime    <= '0;
      cpu_shift <= oomvs_pkg::CPU_SHIFT_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        oomvs_pkg::CFG_UPTIME: uptime <= cfg_ch.data;
        oomvs_pkg::CFG_SHIFT:  cpu_shift <= cfg_ch.data[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    au_start <= 1'b0;
    if (rst) begin
      state       <= S_IDLE;
      pend_valid  <= 1'b0;
      have_choice <= 1'b0;
      aborted     <= 1'b0;
      chosen_id   <= '0;
      top_score   <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            cur_cmd    <= in_ch.cmd;
            word_id    <= in_ch.task_id;
            word_vm    <= in_ch.vm_pages;
            word_cpu   <= in_ch.cpu_jiffies;
            word_start <= in_ch.start_seconds;
            word_attrs <= in_ch.attributes;
            word_adj   <= in_ch.adjust;
            case (in_ch.cmd)
              oomvs_pkg::CMD_TASK, oomvs_pkg::CMD_END: state <= S_JUDGE;
              oomvs_pkg::CMD_CHILD: begin
                if (pend_valid && !aborted && in_ch.attributes[oomvs_pkg::AT_HAS_MM]
                    && !in_ch.attributes[oomvs_pkg::AT_SHARES_MM])
                  pend_points <= pend_points + child_add;
              end
              default: ;
            endcase
          end
        end
        S_JUDGE: begin
          state <= S_LOAD;
          if (pend_valid && !aborted) begin
            pend_valid <= 1'b0;
            if (!pend_attrs[oomvs_pkg::AT_HAS_MM] || pend_attrs[oomvs_pkg::AT_INIT]) begin
              state <= S_LOAD;
            end else if (pend_attrs[oomvs_pkg::AT_MEMDIE] ||
                (pend_attrs[oomvs_pkg::AT_EXITING] && !pend_attrs[oomvs_pkg::AT_CURRENT])) begin
              aborted <= 1'b1;
            end else begin
              if (pend_attrs[oomvs_pkg::AT_EXITING]) begin
                have_choice <= 1'b1;
                chosen_id   <= pend_id;
                top_score   <= '1;
              end
              if (!pend_attrs[oomvs_pkg::AT_DISABLED]) begin
                pts <= pend_points;
                if (pend_attrs[oomvs_pkg::AT_SWAPOFF]) begin
                  pts   <= '1;
                  state <= S_UPDATE;
                end else begin
                  au_start <= 1'b1;
                  au_sqrt  <= 1'b1;
                  au_a     <= cpu_sh;
                  state    <= S_SQ1;
                end
              end
            end
          end
        end
        S_SQ1: if (au_done) begin
          if (au_res != '0) begin
            au_start <= 1'b1; au_sqrt <= 1'b0; au_a <= pts; state <= S_DIV1;
          end else begin
            au_start <= 1'b1; au_sqrt <= 1'b1; au_a <= W'(run_t); state <= S_SQ2;
          end
        end
        S_DIV1: if (au_done) begin
          pts <= au_res;
          au_start <= 1'b1; au_sqrt <= 1'b1; au_a <= W'(run_t); state <= S_SQ2;
        end
        S_SQ2: if (au_done) begin
          au_start <= 1'b1; au_sqrt <= 1'b1; au_a <= au_res; state <= S_SQ3;
        end
        S_SQ3: if (au_done) begin
          if (au_res != '0) begin
            au_start <= 1'b1; au_sqrt <= 1'b0; au_a <= pts; state <= S_DIV2;
          end else begin
            state <= S_FIN;
          end
        end
        S_DIV2: if (au_done) begin
          pts <= au_res; state <= S_FIN;
        end
        S_FIN: begin
          pts <= p_adj; state <= S_UPDATE;
        end
        S_UPDATE: begin
          // strictly greater replaces; first scored task always taken
          if (pts > top_score || !have_choice) begin
            have_choice <= 1'b1;
            chosen_id   <= pend_id;
            top_score   <= pts;
          end
          state <= S_LOAD;
        end
        S_LOAD: begin
          if (cur_cmd == oomvs_pkg::CMD_TASK) begin
            state <= S_IDLE;
            if (!aborted) begin
              pend_valid  <= 1'b1;
              pend_id     <= word_id;
              pend_points <= W'(word_vm);
              pend_cpu    <= word_cpu;
              pend_start  <= word_start;
              pend_attrs  <= word_attrs;
              pend_adjust <= word_adj;
            end
          end else begin
            out_ch.valid <= 1'b1;
            if (aborted) begin
              out_ch.status <= oomvs_pkg::ST_ABORT;
              out_ch.chosen_task <= '0; out_ch.best_score <= '0;
            end else if (have_choice) begin
              out_ch.status <= oomvs_pkg::ST_CHOSEN;
              out_ch.chosen_task <= chosen_id; out_ch.best_score <= 64'(top_score);
            end else begin
              out_ch.status <= oomvs_pkg::ST_NONE;
              out_ch.chosen_task <= '0; out_ch.best_score <= '0;
            end
            pend_valid <= 1'b0; have_choice <= 1'b0; aborted <= 1'b0;
            chosen_id <= '0; top_score <= '0;
            state <= S_OUT;
          end
        end
        S_OUT: if (out_ch.ready) begin
          out_ch.valid <= 1'b0; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // task fields are captured when the word is accepted and loaded in S_LOAD
  `CHK_IMPL(a_out_only_in_out, clk, rst, out_ch.valid, state == S_OUT, "result outside output state")
  `CHK_IMPL(a_abort_no_choice_out, clk, rst, out_ch.valid && out_ch.status == oomvs_pkg::ST_ABORT, out_ch.chosen_task == '0, "abort with id")
  `CHK_NEXT(a_out_clears, clk, rst, state == S_OUT && out_ch.ready, state == S_IDLE && !out_ch.valid, "result not retired")
endmodule
